// ===== rtl/tti_pkg.sv =====
// Package for the thermistor table interpolator: widths, FSM state type and
// the resistance/temperature ROM as constant functions. No dependencies.
package tti_pkg;

  localparam int RES_W    = 23;             // resistance, 0.1 ohm
  localparam int TEMP_W   = 15;             // temperature, 0.01 degC, signed
  localparam int DT_W     = 10;             // temperature step between rows
  localparam int NUM_W    = RES_W + DT_W;   // product of offset and step
  localparam int IDX_W    = 6;
  localparam int ROM_ROWS = 60;
  localparam int CNT_W    = 4;              // counts DT_W serial steps

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tti_state_t;

  function automatic logic [RES_W-1:0] rom_res(input logic [IDX_W-1:0] idx);
    logic [RES_W-1:0] v;
    case (idx)
      6'd0:  v = 23'd6678280;
      6'd1:  v = 23'd3356710;
      6'd2:  v = 23'd1766830;
      6'd3:  v = 23'd969740;
      6'd4:  v = 23'd728950;
      6'd5:  v = 23'd552980;
      6'd6:  v = 23'd423140;
      6'd7:  v = 23'd326500;
      6'd8:  v = 23'd310300;
      6'd9:  v = 23'd295000;
      6'd10: v = 23'd280540;
      6'd11: v = 23'd266880;
      6'd12: v = 23'd253960;
      6'd13: v = 23'd241730;
      6'd14: v = 23'd230160;
      6'd15: v = 23'd219210;
      6'd16: v = 23'd208850;
      6'd17: v = 23'd199040;
      6'd18: v = 23'd189740;
      6'd19: v = 23'd180920;
      6'd20: v = 23'd172570;
      6'd21: v = 23'd164650;
      6'd22: v = 23'd157140;
      6'd23: v = 23'd150010;
      6'd24: v = 23'd143250;
      6'd25: v = 23'd136230;
      6'd26: v = 23'd130530;
      6'd27: v = 23'd124940;
      6'd28: v = 23'd119430;
      6'd29: v = 23'd114200;
      6'd30: v = 23'd109230;
      6'd31: v = 23'd104500;
      6'd32: v = 23'd100000;
      6'd33: v = 23'd95720;
      6'd34: v = 23'd91650;
      6'd35: v = 23'd87770;
      6'd36: v = 23'd84080;
      6'd37: v = 23'd80560;
      6'd38: v = 23'd65300;
      6'd39: v = 23'd53250;
      6'd40: v = 23'd43670;
      6'd41: v = 23'd36010;
      6'd42: v = 23'd29850;
      6'd43: v = 23'd24870;
      6'd44: v = 23'd20820;
      6'd45: v = 23'd17510;
      6'd46: v = 23'd14800;
      6'd47: v = 23'd12560;
      6'd48: v = 23'd10700;
      6'd49: v = 23'd9161;
      6'd50: v = 23'd7870;
      6'd51: v = 23'd6786;
      6'd52: v = 23'd5873;
      6'd53: v = 23'd5101;
      6'd54: v = 23'd4445;
      6'd55: v = 23'd3886;
      6'd56: v = 23'd3408;
      6'd57: v = 23'd3000;
      6'd58: v = 23'd2341;
      6'd59: v = 23'd1848;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TEMP_W-1:0] rom_temp(input logic [IDX_W-1:0] idx);
    logic signed [TEMP_W-1:0] v;
    case (idx)
      6'd0:  v = -15'sd5000;
      6'd1:  v = -15'sd4000;
      6'd2:  v = -15'sd3000;
      6'd3:  v = -15'sd2000;
      6'd4:  v = -15'sd1500;
      6'd5:  v = -15'sd1000;
      6'd6:  v = -15'sd500;
      6'd7:  v = 15'sd0;
      6'd8:  v = 15'sd100;
      6'd9:  v = 15'sd200;
      6'd10: v = 15'sd300;
      6'd11: v = 15'sd400;
      6'd12: v = 15'sd500;
      6'd13: v = 15'sd600;
      6'd14: v = 15'sd700;
      6'd15: v = 15'sd800;
      6'd16: v = 15'sd900;
      6'd17: v = 15'sd1000;
      6'd18: v = 15'sd1100;
      6'd19: v = 15'sd1200;
      6'd20: v = 15'sd1300;
      6'd21: v = 15'sd1400;
      6'd22: v = 15'sd1500;
      6'd23: v = 15'sd1600;
      6'd24: v = 15'sd1700;
      6'd25: v = 15'sd1800;
      6'd26: v = 15'sd1900;
      6'd27: v = 15'sd2000;
      6'd28: v = 15'sd2100;
      6'd29: v = 15'sd2200;
      6'd30: v = 15'sd2300;
      6'd31: v = 15'sd2400;
      6'd32: v = 15'sd2500;
      6'd33: v = 15'sd2600;
      6'd34: v = 15'sd2700;
      6'd35: v = 15'sd2800;
      6'd36: v = 15'sd2900;
      6'd37: v = 15'sd3000;
      6'd38: v = 15'sd3500;
      6'd39: v = 15'sd4000;
      6'd40: v = 15'sd4500;
      6'd41: v = 15'sd5000;
      6'd42: v = 15'sd5500;
      6'd43: v = 15'sd6000;
      6'd44: v = 15'sd6500;
      6'd45: v = 15'sd7000;
      6'd46: v = 15'sd7500;
      6'd47: v = 15'sd8000;
      6'd48: v = 15'sd8500;
      6'd49: v = 15'sd9000;
      6'd50: v = 15'sd9500;
      6'd51: v = 15'sd10000;
      6'd52: v = 15'sd10500;
      6'd53: v = 15'sd11000;
      6'd54: v = 15'sd11500;
      6'd55: v = 15'sd12000;
      6'd56: v = 15'sd12500;
      6'd57: v = 15'sd13000;
      6'd58: v = 15'sd14000;
      6'd59: v = 15'sd15000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/thermistor_table_interpolator.sv =====
// Thermistor resistance to temperature converter, piecewise linear over a ROM table.
// Depends on tti_pkg (widths, state type, ROM functions).
//
// Takes one resistance (0.1 ohm) at a time and returns one temperature (0.01 degC)
// with an out-of-range flag. The table is searched one row per cycle, then the
// interpolation product is built by a shift-add multiplier one step-bit per cycle
// and divided by a restoring divider one quotient bit per cycle. An out-of-range
// item skips the search and the arithmetic and goes straight to the result.
// in_ready is high while no item is in flight; a finished result waits in the
// output register without blocking the next acceptance.
module thermistor_table_interpolator #(
  parameter int TABLE_ENTRIES = 60
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tti_pkg::RES_W-1:0]           in_resistance_tenths,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tti_pkg::TEMP_W-1:0]   out_temperature_centi,
  output logic                                out_out_of_range
);
  import tti_pkg::*;

  localparam int ROWS_HI = (TABLE_ENTRIES > ROM_ROWS) ? ROM_ROWS : TABLE_ENTRIES;
  localparam int ROWS    = (ROWS_HI < 2) ? 2 : ROWS_HI;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ROWS - 1);

  tti_state_t state_r, state_nxt;

  logic [RES_W-1:0]         r_r,     r_nxt;
  logic [IDX_W-1:0]         idx_r,   idx_nxt;
  logic [CNT_W-1:0]         cnt_r,   cnt_nxt;
  logic [RES_W-1:0]         den_r,   den_nxt;
  logic [DT_W-1:0]          mplr_r,  mplr_nxt;
  logic [NUM_W-1:0]         sh_r,    sh_nxt;
  logic [NUM_W-1:0]         acc_r,   acc_nxt;
  logic [DT_W-1:0]          q_r,     q_nxt;
  logic signed [TEMP_W-1:0] base_r,  base_nxt;
  logic                     oor_r,   oor_nxt;
  logic                     ovld_r,  ovld_nxt;
  logic signed [TEMP_W-1:0] otemp_r, otemp_nxt;
  logic                     ooor_r,  ooor_nxt;

  logic                     accept;
  logic                     in_oor;
  logic                     hit;
  logic                     cnt_done;
  logic                     out_free;
  logic [RES_W-1:0]         res_cur;
  logic [RES_W-1:0]         res_prev;
  logic signed [TEMP_W-1:0] temp_cur;
  logic signed [TEMP_W-1:0] temp_prev;
  logic signed [TEMP_W-1:0] temp_step;
  logic                     div_ge;

  assign accept   = in_valid && in_ready;
  assign in_oor   = (in_resistance_tenths > rom_res('0)) ||
                    (in_resistance_tenths < rom_res(LAST));
  assign res_cur  = rom_res(idx_r);
  assign res_prev = rom_res(idx_r - 1'b1);
  assign temp_cur  = rom_temp(idx_r);
  assign temp_prev = rom_temp(idx_r - 1'b1);
  assign temp_step = temp_cur - temp_prev;
  assign hit      = r_r > res_cur;
  assign cnt_done = (cnt_r == '0);
  assign out_free = !ovld_r || out_ready;
  assign div_ge   = (acc_r >= sh_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_oor ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = ST_MUL;
        end else if (idx_r == LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        if (cnt_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  // Datapath
  always_comb begin
    r_nxt     = r_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    den_nxt   = den_r;
    mplr_nxt  = mplr_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    base_nxt  = base_r;
    oor_nxt   = oor_r;
    ovld_nxt  = ovld_r && !out_ready;
    otemp_nxt = otemp_r;
    ooor_nxt  = ooor_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          r_nxt    = in_resistance_tenths;
          idx_nxt  = IDX_W'(1);
          oor_nxt  = in_oor;
          base_nxt = '0;
          q_nxt    = '0;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          acc_nxt  = '0;
          sh_nxt   = NUM_W'(r_r - res_cur);
          mplr_nxt = DT_W'(temp_step);
          den_nxt  = res_prev - res_cur;
          base_nxt = temp_cur;
          cnt_nxt  = CNT_W'(DT_W - 1);
        end else if (idx_r == LAST) begin
          // input equals the last row: its temperature, no correction
          base_nxt = temp_cur;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MUL: begin
        if (mplr_r[0]) begin
          acc_nxt = acc_r + sh_r;
        end
        mplr_nxt = mplr_r >> 1;
        sh_nxt   = sh_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_done) begin
          // load the divisor aligned to the top quotient bit
          sh_nxt  = NUM_W'(den_r) << (DT_W - 1);
          cnt_nxt = CNT_W'(DT_W - 1);
        end
      end
      ST_DIV: begin
        if (div_ge) begin
          acc_nxt = acc_r - sh_r;
        end
        q_nxt   = {q_r[DT_W-2:0], div_ge};
        sh_nxt  = sh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          otemp_nxt = base_r - $signed({{(TEMP_W - DT_W){1'b0}}, q_r});
          ooor_nxt  = oor_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    den_r   <= den_nxt;
    mplr_r  <= mplr_nxt;
    sh_r    <= sh_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    base_r  <= base_nxt;
    oor_r   <= oor_nxt;
    otemp_r <= otemp_nxt;
    ooor_r  <= ooor_nxt;
  end

  assign out_valid             = ovld_r;
  assign out_temperature_centi = otemp_r;
  assign out_out_of_range      = ooor_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted transaction did not start processing");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> {1'b0, acc_r} < {sh_r, 1'b0})
    else $error("partial remainder exceeds divider range");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_temperature_centi == '0)
    else $error("out-of-range result carries nonzero temperature");

  a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      (out_temperature_centi >= -15'sd5000) && (out_temperature_centi <= 15'sd15000))
    else $error("interpolated temperature outside table span");

endmodule
